@@ hdl/triangle_face_normal_assert.svh @@
// Assertion macros for the triangle face normal block.
// Expects signals clk and rst_n in the scope of use.
`ifndef TRIANGLE_FACE_NORMAL_ASSERT_SVH
`define TRIANGLE_FACE_NORMAL_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define TFN_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define TFN_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/tfn_pkg.sv @@
// Shared constants and types for the triangle face normal block.
// No dependencies.
`timescale 1ns / 1ps

package tfn_pkg;
  localparam int COORD_BITS_DEF = 18;
  localparam int FRAC_BITS_DEF  = 15;
  localparam int NORM_BITS      = 30;
  localparam int ROOT_BITS      = NORM_BITS + 1;
  localparam int SQ_BITS        = 2 * NORM_BITS + 2;
  localparam int OUT_BITS       = 16;
  localparam logic [OUT_BITS-1:0] OUT_POS_LIM = 16'h7fff;
  localparam logic [OUT_BITS-1:0] OUT_NEG_LIM = 16'h8000;

  typedef struct packed {
    logic [2:0] neg;
    logic       degen;
  } tfn_side_t;
endpackage

@@ hdl/tfn_cross.sv @@
// Front end: edge vectors, cross product and sign/magnitude split.
// Depends on tfn_pkg.
`timescale 1ns / 1ps

module tfn_cross import tfn_pkg::*; #(
  parameter int CB = COORD_BITS_DEF,
  parameter int MW = 2 * CB + 2
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 vld_i,
  input  logic signed [CB-1:0] crd_i [9],
  output logic                 vld_o,
  output logic [MW-1:0]        mag_o [3],
  output tfn_side_t            side_o
);
  logic [3:0] vld_r;
  logic signed [CB:0]     e1_r [3];
  logic signed [CB:0]     e2_r [3];
  logic signed [2*CB+1:0] pr_r [6];
  logic signed [2*CB+2:0] n_r  [3];
  logic [MW-1:0]          mag_r [3];
  tfn_side_t              side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[2:0], vld_i};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        e1_r[i] <= {crd_i[3+i][CB-1], crd_i[3+i]} - {crd_i[i][CB-1], crd_i[i]};
        e2_r[i] <= {crd_i[6+i][CB-1], crd_i[6+i]} - {crd_i[3+i][CB-1], crd_i[3+i]};
      end
      pr_r[0] <= e1_r[1] * e2_r[2];
      pr_r[1] <= e1_r[2] * e2_r[1];
      pr_r[2] <= e1_r[2] * e2_r[0];
      pr_r[3] <= e1_r[0] * e2_r[2];
      pr_r[4] <= e1_r[0] * e2_r[1];
      pr_r[5] <= e1_r[1] * e2_r[0];
      for (int i = 0; i < 3; i++) begin
        n_r[i] <= {pr_r[2*i][2*CB+1], pr_r[2*i]} - {pr_r[2*i+1][2*CB+1], pr_r[2*i+1]};
        side_r.neg[i] <= n_r[i][2*CB+2];
        mag_r[i] <= n_r[i][2*CB+2] ? MW'(-n_r[i]) : MW'(n_r[i]);
      end
      side_r.degen <= (n_r[0] == '0) && (n_r[1] == '0) && (n_r[2] == '0);
    end
  end

  assign vld_o  = vld_r[3];
  assign mag_o  = mag_r;
  assign side_o = side_r;
endmodule

@@ hdl/tfn_norm_cell.sv @@
// Normalizer cell: shifts three magnitudes left by SH when the top SH bits are clear.
// Depends on tfn_pkg.
`timescale 1ns / 1ps

module tfn_norm_cell import tfn_pkg::*; #(
  parameter int W  = 38,
  parameter int SH = 1
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         en,
  input  logic         vld_i,
  input  logic [W-1:0] mag_i [3],
  input  tfn_side_t    side_i,
  output logic         vld_o,
  output logic [W-1:0] mag_o [3],
  output tfn_side_t    side_o
);
  logic         vld_r;
  logic [W-1:0] mag_r [3];
  tfn_side_t    side_r;
  logic         clear;

  assign clear = ~|(mag_i[0][W-1 -: SH] | mag_i[1][W-1 -: SH] | mag_i[2][W-1 -: SH]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        mag_r[i] <= clear ? (mag_i[i] << SH) : mag_i[i];
      end
      side_r <= side_i;
    end
  end

  assign vld_o  = vld_r;
  assign mag_o  = mag_r;
  assign side_o = side_r;
endmodule

@@ hdl/tfn_sqrt_cell.sv @@
// Square root cell: decides one root bit and passes a payload along.
// Depends on tfn_pkg.
`timescale 1ns / 1ps

module tfn_sqrt_cell import tfn_pkg::*; #(
  parameter int BIT = 0,
  parameter int PW  = 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 vld_i,
  input  logic [SQ_BITS-1:0]   rem_i,
  input  logic [ROOT_BITS-1:0] root_i,
  input  logic [PW-1:0]        pay_i,
  output logic                 vld_o,
  output logic [SQ_BITS-1:0]   rem_o,
  output logic [ROOT_BITS-1:0] root_o,
  output logic [PW-1:0]        pay_o
);
  logic                 vld_r;
  logic [SQ_BITS-1:0]   rem_r;
  logic [ROOT_BITS-1:0] root_r;
  logic [PW-1:0]        pay_r;
  logic [SQ_BITS-1:0]   sub;
  logic                 ge;

  assign sub = (SQ_BITS'(root_i) << (BIT + 1)) | (SQ_BITS'(1) << (2 * BIT));
  assign ge  = rem_i >= sub;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r  <= ge ? rem_i - sub : rem_i;
      root_r <= ge ? (root_i | (ROOT_BITS'(1) << BIT)) : root_i;
      pay_r  <= pay_i;
    end
  end

  assign vld_o  = vld_r;
  assign rem_o  = rem_r;
  assign root_o = root_r;
  assign pay_o  = pay_r;
endmodule

@@ hdl/tfn_div_cell.sv @@
// Divider cell: one quotient bit for each of three lanes sharing one divisor.
// Depends on tfn_pkg.
`timescale 1ns / 1ps

module tfn_div_cell import tfn_pkg::*; #(
  parameter int QW = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 vld_i,
  input  logic [ROOT_BITS-1:0] den_i,
  input  logic [ROOT_BITS-1:0] rem_i [3],
  input  logic [QW-1:0]        lo_i  [3],
  input  logic [QW-1:0]        q_i   [3],
  input  tfn_side_t            side_i,
  output logic                 vld_o,
  output logic [ROOT_BITS-1:0] den_o,
  output logic [ROOT_BITS-1:0] rem_o [3],
  output logic [QW-1:0]        lo_o  [3],
  output logic [QW-1:0]        q_o   [3],
  output tfn_side_t            side_o
);
  logic                 vld_r;
  logic [ROOT_BITS-1:0] den_r;
  logic [ROOT_BITS-1:0] rem_r [3];
  logic [QW-1:0]        lo_r  [3];
  logic [QW-1:0]        q_r   [3];
  tfn_side_t            side_r;
  logic [ROOT_BITS:0]   t    [3];
  logic [ROOT_BITS:0]   diff [3];
  logic [2:0]           ge;

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      t[l]    = {rem_i[l], lo_i[l][QW-1]};
      diff[l] = t[l] - {1'b0, den_i};
      ge[l]   = t[l] >= {1'b0, den_i};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 3; l++) begin
        rem_r[l] <= ge[l] ? diff[l][ROOT_BITS-1:0] : t[l][ROOT_BITS-1:0];
        lo_r[l]  <= lo_i[l] << 1;
        q_r[l]   <= {q_i[l][QW-2:0], ge[l]};
      end
      den_r  <= den_i;
      side_r <= side_i;
    end
  end

  assign vld_o  = vld_r;
  assign den_o  = den_r;
  assign rem_o  = rem_r;
  assign lo_o   = lo_r;
  assign q_o    = q_r;
  assign side_o = side_r;
endmodule

@@ hdl/triangle_face_normal.sv @@
// Throughput: one request per cycle while no result waits unread; every stage hands on each enabled cycle.
// The whole chain advances together and halts only while a result waits unread.
// The root takes 31 cells and the divide NORMAL_FRAC_BITS+1 cells of the chain.
// Reset (rst_n, synchronous, active low) clears all valid flags; data is not reset.
`timescale 1ns / 1ps
`include "triangle_face_normal_assert.svh"

module triangle_face_normal import tfn_pkg::*; #(
  parameter int COORD_BITS       = COORD_BITS_DEF,
  parameter int NORMAL_FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  // first_x, first_y, first_z, second_x, second_y, second_z, third_x, third_y, third_z
  input  logic [((9*COORD_BITS+7)/8)*8-1:0] in_tdata,
  output logic out_tvalid,
  input  logic out_tready,
  // normal_x, normal_y, normal_z
  output logic [3*OUT_BITS-1:0] out_tdata,
  // degenerate
  output logic out_tuser
);
  localparam int MW  = 2 * COORD_BITS + 2;
  localparam int NW  = (MW > NORM_BITS) ? MW : NORM_BITS;
  localparam int NSH = $clog2(NW);
  localparam int PW  = 4 + 3 * NORM_BITS;
  localparam int QW  = NORMAL_FRAC_BITS + 1;
  localparam int DW  = NORM_BITS + NORMAL_FRAC_BITS + 1;
  localparam int XW  = (QW > OUT_BITS + 1) ? QW : OUT_BITS + 1;

  logic en;
  logic signed [COORD_BITS-1:0] crd [9];

  logic      cr_vld;
  logic [MW-1:0] cr_mag [3];
  tfn_side_t cr_side;

  logic          n_vld  [NSH+1];
  logic [NW-1:0] n_mag  [NSH+1][3];
  tfn_side_t     n_side [NSH+1];

  logic                   sq_vld_r, sum_vld_r;
  logic [2*NORM_BITS-1:0] sq_r [3];
  logic [NORM_BITS-1:0]   m1_r [3];
  logic [NORM_BITS-1:0]   m2_r [3];
  tfn_side_t              sq_side_r, sum_side_r;
  logic [SQ_BITS-1:0]     s_r;

  logic                 s_vld  [ROOT_BITS+1];
  logic [SQ_BITS-1:0]   s_rem  [ROOT_BITS+1];
  logic [ROOT_BITS-1:0] s_root [ROOT_BITS+1];
  logic [PW-1:0]        s_pay  [ROOT_BITS+1];

  tfn_side_t            sq_out_side;
  logic [NORM_BITS-1:0] sq_out_m [3];
  logic [DW-1:0]        dvd [3];

  logic                 d_vld  [QW+1];
  logic [ROOT_BITS-1:0] d_den  [QW+1];
  logic [ROOT_BITS-1:0] d_rem  [QW+1][3];
  logic [QW-1:0]        d_lo   [QW+1][3];
  logic [QW-1:0]        d_q    [QW+1][3];
  tfn_side_t            d_side [QW+1];

  logic                out_vld_r;
  logic [OUT_BITS-1:0] out_n_r [3];
  logic                out_degen_r;
  logic [XW-1:0]       qx [3];
  logic [OUT_BITS-1:0] nrm [3];

  assign en        = !out_vld_r || out_tready;
  assign in_tready = en;

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      crd[i] = in_tdata[i*COORD_BITS +: COORD_BITS];
    end
  end

  tfn_cross #(.CB(COORD_BITS), .MW(MW)) u_cross (
    .clk(clk), .rst_n(rst_n), .en(en),
    .vld_i(in_tvalid && in_tready), .crd_i(crd),
    .vld_o(cr_vld), .mag_o(cr_mag), .side_o(cr_side)
  );

  always_comb begin
    n_vld[0]  = cr_vld;
    n_side[0] = cr_side;
    for (int i = 0; i < 3; i++) begin
      n_mag[0][i] = NW'(cr_mag[i]);
    end
  end

  for (genvar k = 0; k < NSH; k++) begin : g_norm
    tfn_norm_cell #(.W(NW), .SH(1 << (NSH - 1 - k))) u_cell (
      .clk(clk), .rst_n(rst_n), .en(en),
      .vld_i(n_vld[k]), .mag_i(n_mag[k]), .side_i(n_side[k]),
      .vld_o(n_vld[k+1]), .mag_o(n_mag[k+1]), .side_o(n_side[k+1])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_vld_r  <= 1'b0;
      sum_vld_r <= 1'b0;
    end else if (en) begin
      sq_vld_r  <= n_vld[NSH];
      sum_vld_r <= sq_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        m1_r[i] <= n_mag[NSH][i][NW-1 -: NORM_BITS];
        sq_r[i] <= n_mag[NSH][i][NW-1 -: NORM_BITS] * n_mag[NSH][i][NW-1 -: NORM_BITS];
        m2_r[i] <= m1_r[i];
      end
      sq_side_r  <= n_side[NSH];
      s_r        <= SQ_BITS'(sq_r[0]) + SQ_BITS'(sq_r[1]) + SQ_BITS'(sq_r[2]);
      sum_side_r <= sq_side_r;
    end
  end

  assign s_vld[0]  = sum_vld_r;
  assign s_rem[0]  = s_r;
  assign s_root[0] = '0;
  assign s_pay[0]  = {sum_side_r, m2_r[0], m2_r[1], m2_r[2]};

  for (genvar j = 0; j < ROOT_BITS; j++) begin : g_sqrt
    tfn_sqrt_cell #(.BIT(ROOT_BITS - 1 - j), .PW(PW)) u_cell (
      .clk(clk), .rst_n(rst_n), .en(en),
      .vld_i(s_vld[j]), .rem_i(s_rem[j]), .root_i(s_root[j]), .pay_i(s_pay[j]),
      .vld_o(s_vld[j+1]), .rem_o(s_rem[j+1]), .root_o(s_root[j+1]), .pay_o(s_pay[j+1])
    );
  end

  assign {sq_out_side, sq_out_m[0], sq_out_m[1], sq_out_m[2]} = s_pay[ROOT_BITS];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dvd[i] = {1'b0, sq_out_m[i], {NORMAL_FRAC_BITS{1'b0}}}
             + DW'(s_root[ROOT_BITS] >> 1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_vld[0] <= 1'b0;
    end else if (en) begin
      d_vld[0] <= s_vld[ROOT_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_den[0]  <= s_root[ROOT_BITS];
      d_side[0] <= sq_out_side;
      for (int i = 0; i < 3; i++) begin
        d_rem[0][i] <= ROOT_BITS'(dvd[i] >> QW);
        d_lo[0][i]  <= dvd[i][QW-1:0];
        d_q[0][i]   <= '0;
      end
    end
  end

  for (genvar j = 0; j < QW; j++) begin : g_div
    tfn_div_cell #(.QW(QW)) u_cell (
      .clk(clk), .rst_n(rst_n), .en(en),
      .vld_i(d_vld[j]), .den_i(d_den[j]), .rem_i(d_rem[j]), .lo_i(d_lo[j]),
      .q_i(d_q[j]), .side_i(d_side[j]),
      .vld_o(d_vld[j+1]), .den_o(d_den[j+1]), .rem_o(d_rem[j+1]), .lo_o(d_lo[j+1]),
      .q_o(d_q[j+1]), .side_o(d_side[j+1])
    );
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      qx[i] = XW'(d_q[QW][i]);
      if (d_side[QW].degen) begin
        nrm[i] = '0;
      end else if (d_side[QW].neg[i]) begin
        nrm[i] = (qx[i] > XW'(OUT_NEG_LIM)) ? OUT_NEG_LIM : OUT_BITS'(~qx[i][OUT_BITS-1:0] + 1'b1);
      end else begin
        nrm[i] = (qx[i] > XW'(OUT_POS_LIM)) ? OUT_POS_LIM : qx[i][OUT_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= d_vld[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_n_r     <= nrm;
      out_degen_r <= d_side[QW].degen;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {out_n_r[2], out_n_r[1], out_n_r[0]};
  assign out_tuser  = out_degen_r;

  `TFN_ASSERT_IMPL(a_degen_zero, out_tvalid && out_tuser, out_tdata == '0, "degenerate result with nonzero normal")
  `TFN_ASSERT_IMPL(a_unit_nonzero, out_tvalid && !out_tuser, out_tdata != '0, "zero normal without degenerate flag")
  `TFN_ASSERT_IMPL(a_stall_cause, !in_tready, out_tvalid && !out_tready, "input stalled without a waiting result")
  `TFN_ASSERT_NEXT(a_hold_result, out_tvalid && !out_tready, out_tvalid, "waiting result dropped")
endmodule
